### hdl/lpt_pkg.sv
// Shared types and constants for the IPv4 longest-prefix trie.
// Used by the front, the queue, the engine and the top level; depends on nothing.
`timescale 1ns / 1ps

package lpt_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int AS_W        = 32;
    localparam int PLEN_W      = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DUP  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // Request transaction as it arrives
    typedef struct packed {
        logic                  kind;
        logic [ADDR_BITS-1:0]  address;
        logic [PLEN_W-1:0]     prefix_length;
        logic [AS_W-1:0]       as_number;
    } req_t;

    // Response transaction
    typedef struct packed {
        logic [AS_W-1:0] found_as;
        logic [1:0]      status;
    } rsp_t;

    // Classified command handed from the front to the engine
    typedef struct packed {
        logic                  is_lookup;
        logic [ADDR_BITS-1:0]  address;
        logic [PLEN_W-1:0]     prefix_length;
        logic [AS_W-1:0]       as_number;
    } cmd_t;

    // Address bit that steers the walk at a given depth (depth below ADDR_BITS)
    function automatic logic addr_bit(logic [ADDR_BITS-1:0] addr, logic [PLEN_W-1:0] depth);
        logic [4:0] pos;
        pos = 5'(ADDR_BITS - 1) - depth[4:0];
        return addr[pos];
    endfunction

endpackage

### hdl/lpt_front.sv
// Front stage of the trie: accepts request transactions and classifies them.
// Depends on lpt_pkg; feeds lpt_queue.
`timescale 1ns / 1ps

module lpt_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  lpt_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output lpt_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_stall
);

    logic          valid_reg;
    logic          valid_next;
    lpt_pkg::cmd_t cmd_reg;
    lpt_pkg::cmd_t cmd_next;
    logic          take_in;

    // Hold the stage while the queue refuses it
    assign req_stall = valid_reg && cmd_stall;
    assign take_in   = req_valid && !req_stall;

    // Decode kind and saturate the prefix length
    always_comb
    begin
        cmd_next = cmd_reg;
        valid_next = valid_reg && cmd_stall;
        if (take_in)
        begin
            valid_next              = 1'b1;
            cmd_next.is_lookup      = (req.kind == lpt_pkg::KIND_LOOKUP);
            cmd_next.address        = req.address;
            cmd_next.as_number      = req.as_number;
            if (req.prefix_length > lpt_pkg::PLEN_W'(lpt_pkg::ADDR_BITS))
                cmd_next.prefix_length = lpt_pkg::PLEN_W'(lpt_pkg::ADDR_BITS);
            else
                cmd_next.prefix_length = req.prefix_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

### hdl/lpt_queue.sv
// Short command queue between the trie front and the trie engine.
// Depends on lpt_pkg.
`timescale 1ns / 1ps

module lpt_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  lpt_pkg::cmd_t wr_cmd,
    input  logic          wr_valid,
    output logic          wr_stall,
    output lpt_pkg::cmd_t rd_cmd,
    output logic          rd_valid,
    input  logic          rd_stall
);

    localparam int PTR_W = $clog2(lpt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lpt_pkg::QUEUE_DEPTH + 1);

    lpt_pkg::cmd_t    slot_reg [lpt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_stall = (count_reg == CNT_W'(lpt_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(lpt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(lpt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

### hdl/lpt_engine.sv
// Back stage of the trie: node memory, walk sequencer and response register.
// Depends on lpt_pkg; takes commands from lpt_queue.
`timescale 1ns / 1ps

module lpt_engine
#(
    parameter int NODE_COUNT = 4096
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lpt_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    output lpt_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int CNT_W   = $clog2(NODE_COUNT + 1);
    localparam int AS_W    = lpt_pkg::AS_W;
    localparam int ENTRY_W = 2 * NODE_W + AS_W;
    localparam int PLEN_W  = lpt_pkg::PLEN_W;

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_FILL, S_FINISH} state_t;

    // Node memory: {child1, child0, AS number}
    logic [ENTRY_W-1:0] node_mem [NODE_COUNT];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               rd_en;
    logic [NODE_W-1:0]  rd_addr;
    logic               wr_en;
    logic [NODE_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    state_t             state_reg, state_next;
    lpt_pkg::cmd_t      cmd_reg, cmd_next;
    logic [PLEN_W-1:0]  depth_reg, depth_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [NODE_W-1:0]  alloc_reg, alloc_next;
    logic [AS_W-1:0]    found_reg, found_next;
    logic [CNT_W-1:0]   nodes_used_reg, nodes_used_next;
    lpt_pkg::rsp_t      result_reg, result_next;
    lpt_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [NODE_W-1:0]  rd_kid0;
    logic [NODE_W-1:0]  rd_kid1;
    logic [AS_W-1:0]    rd_asn;
    logic               step_bit;
    logic [NODE_W-1:0]  child;
    logic [NODE_W-1:0]  link;
    logic [AS_W-1:0]    best_as;
    logic [CNT_W-1:0]   need;
    logic [CNT_W-1:0]   free_nodes;
    logic               at_prefix_end;
    logic               at_addr_end;

    assign rd_kid1       = rd_data_reg[ENTRY_W-1 -: NODE_W];
    assign rd_kid0       = rd_data_reg[AS_W +: NODE_W];
    assign rd_asn        = rd_data_reg[AS_W-1:0];
    assign step_bit      = lpt_pkg::addr_bit(cmd_reg.address, depth_reg);
    assign child         = step_bit ? rd_kid1 : rd_kid0;
    assign link          = alloc_reg + 1'b1;
    assign best_as       = (rd_asn != '0) ? rd_asn : found_reg;
    assign need          = CNT_W'(cmd_reg.prefix_length - depth_reg);
    assign free_nodes    = CNT_W'(NODE_COUNT) - nodes_used_reg;
    assign at_prefix_end = (depth_reg == cmd_reg.prefix_length);
    assign at_addr_end   = (depth_reg == PLEN_W'(lpt_pkg::ADDR_BITS));

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // Sequence one trie level per cycle
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        depth_next      = depth_reg;
        cur_next        = cur_reg;
        alloc_next      = alloc_reg;
        found_next      = found_reg;
        nodes_used_next = nodes_used_reg;
        result_next     = result_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rd_en           = 1'b0;
        rd_addr         = child;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = {rd_kid1, rd_kid0, cmd_reg.as_number};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    depth_next = '0;
                    cur_next   = '0;
                    found_next = '0;
                    alloc_next = '0;
                    if (nodes_used_reg == '0)
                    begin
                        if (cmd.is_lookup)
                        begin
                            result_next = '{found_as: '0, status: lpt_pkg::STATUS_OK};
                            state_next  = S_FINISH;
                        end
                        else
                            state_next = S_FILL;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_WALK;
                    end
                end
            end

            S_WALK:
            begin
                if (cmd_reg.is_lookup)
                begin
                    // Track the deepest nonzero AS number on the path
                    if (at_addr_end || child == '0)
                    begin
                        result_next = '{found_as: best_as, status: lpt_pkg::STATUS_OK};
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        cur_next   = child;
                        depth_next = depth_reg + 1'b1;
                        found_next = best_as;
                    end
                end
                else if (at_prefix_end)
                begin
                    // Final node exists: store unless already taken
                    result_next.found_as = '0;
                    if (rd_asn != '0)
                        result_next.status = lpt_pkg::STATUS_DUP;
                    else
                    begin
                        wr_en              = 1'b1;
                        result_next.status = lpt_pkg::STATUS_OK;
                    end
                    state_next = S_FINISH;
                end
                else if (child != '0)
                begin
                    rd_en      = 1'b1;
                    cur_next   = child;
                    depth_next = depth_reg + 1'b1;
                end
                else if (need > free_nodes)
                begin
                    result_next = '{found_as: '0, status: lpt_pkg::STATUS_FULL};
                    state_next  = S_FINISH;
                end
                else
                begin
                    // Link the parent to the first new node of the chain
                    wr_en      = 1'b1;
                    wr_data    = step_bit
                                 ? {nodes_used_reg[NODE_W-1:0], rd_kid0, rd_asn}
                                 : {rd_kid1, nodes_used_reg[NODE_W-1:0], rd_asn};
                    alloc_next = nodes_used_reg[NODE_W-1:0];
                    depth_next = depth_reg + 1'b1;
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                // Write one freshly allocated node per cycle
                wr_en           = 1'b1;
                wr_addr         = alloc_reg;
                nodes_used_next = nodes_used_reg + 1'b1;
                if (at_prefix_end)
                begin
                    wr_data     = {{(2 * NODE_W){1'b0}}, cmd_reg.as_number};
                    result_next = '{found_as: '0, status: lpt_pkg::STATUS_OK};
                    state_next  = S_FINISH;
                end
                else
                begin
                    wr_data    = step_bit ? {link, {NODE_W{1'b0}}, {AS_W{1'b0}}}
                                          : {{NODE_W{1'b0}}, link, {AS_W{1'b0}}};
                    alloc_next = link;
                    depth_next = depth_reg + 1'b1;
                end
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = result_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        depth_reg  <= depth_next;
        cur_reg    <= cur_next;
        alloc_reg  <= alloc_next;
        found_reg  <= found_next;
        result_reg <= result_next;
        rsp_reg    <= rsp_next;
    end

    // Node memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            node_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= node_mem[rd_addr];
    end

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg <= CNT_W'(NODE_COUNT))
        else $error("node pool count beyond capacity");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("node memory read and write in the same cycle");

    a_lookup_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && cmd_reg.is_lookup) |-> result_reg.status == lpt_pkg::STATUS_OK)
        else $error("lookup finished with nonzero status");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=> nodes_used_reg == $past(nodes_used_reg) + 1'b1)
        else $error("node allocation did not advance the pool");

    a_insert_no_as: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !cmd_reg.is_lookup) |-> result_reg.found_as == '0)
        else $error("insert returned an AS number");

endmodule

### hdl/ipv4_longest_prefix_trie_top.sv
// Each transaction is registered in the front stage and held in the queue; the engine takes it
// from the queue when idle. It visits one trie level per cycle through the single read port of
// the node memory, or allocates one node per cycle through its write port. The levels visited and
// nodes allocated are at most 33 together, since the walk stops where allocation begins. It then
// hands over the response through its response register, and it takes no new command until that
// is done, so it works on one transaction at a time. The node memory needs no clearing after
// reset, since every node is written when it is allocated. Two queued commands and a response
// register let new requests arrive while a result waits to be taken.
`timescale 1ns / 1ps

module ipv4_longest_prefix_trie_top
#(
    parameter int NODE_COUNT = 4096
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lpt_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output lpt_pkg::rsp_t rsp,
    output logic          rsp_valid,
    input  logic          rsp_stall
);

    lpt_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          front_stall;
    lpt_pkg::cmd_t queue_cmd;
    logic          queue_valid;
    logic          queue_stall;

    // Accept and classify requests
    lpt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_stall (front_stall)
    );

    // Buffer commands between front and engine
    lpt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cmd   (front_cmd),
        .wr_valid (front_valid),
        .wr_stall (front_stall),
        .rd_cmd   (queue_cmd),
        .rd_valid (queue_valid),
        .rd_stall (queue_stall)
    );

    // Walk the trie and produce responses
    lpt_engine #(
        .NODE_COUNT (NODE_COUNT)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_valid (queue_valid),
        .cmd_stall (queue_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

endmodule

### tb/tb.sv
// Self-checking bench for the IPv4 longest-prefix trie: it mirrors the trie, compares
// every response in order, and runs directed, random, backpressure and pool-exhaustion tests.
// Depends on lpt_pkg and ipv4_longest_prefix_trie_top.
`timescale 1ns / 1ps

module tb;

    localparam int ADDR_BITS   = lpt_pkg::ADDR_BITS;
    localparam int PLEN_W      = lpt_pkg::PLEN_W;
    localparam int AS_W        = lpt_pkg::AS_W;
    localparam int TRIE_NODES  = 4096;
    localparam int IDX_W       = $clog2(TRIE_NODES);
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        logic [PLEN_W-1:0]    plen;
    } route_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    lpt_pkg::req_t  req       = '0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    lpt_pkg::rsp_t  rsp;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;

    // Mirror of the node pool
    logic [IDX_W-1:0] kid0    [TRIE_NODES];
    logic [IDX_W-1:0] kid1    [TRIE_NODES];
    logic [AS_W-1:0]  node_as [TRIE_NODES];
    logic [IDX_W:0]   trie_used = '0;

    lpt_pkg::rsp_t pending_rsp[$];
    route_t        routes[$];
    lpt_pkg::rsp_t oldest_rsp;
    logic [1:0]    last_status    = lpt_pkg::STATUS_OK;
    int            send_idle_pct  = 0;
    int            rsp_idle_pct   = 0;
    int            hold_cycles    = 0;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;

    ipv4_longest_prefix_trie_top #(.NODE_COUNT(TRIE_NODES)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Count nodes already present on the path of a prefix, root included
    function automatic int path_nodes(logic [ADDR_BITS-1:0] addr, int plen);
        int have;
        int d;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        have = 0;
        cur  = '0;
        if (trie_used != 0)
        begin
            have = 1;
            for (d = 0; d < plen; d++)
            begin
                nxt = addr[ADDR_BITS-1-d] ? kid1[cur] : kid0[cur];
                if (nxt == 0)
                    break;
                cur = nxt;
                have++;
            end
        end
        return have;
    endfunction

    // Allocate and clear the next free node
    function automatic logic [IDX_W-1:0] take_node();
        logic [IDX_W-1:0] idx;
        idx = trie_used[IDX_W-1:0];
        kid0[idx]    = '0;
        kid1[idx]    = '0;
        node_as[idx] = '0;
        trie_used    = trie_used + 1'b1;
        return idx;
    endfunction

    // Apply one transaction to the mirror and return the response it must produce
    function automatic lpt_pkg::rsp_t trie_apply(lpt_pkg::req_t r);
        lpt_pkg::rsp_t res;
        int plen;
        int need;
        int d;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        res = '0;
        cur = '0;
        if (r.kind == lpt_pkg::KIND_LOOKUP)
        begin
            // keep the deepest nonzero AS on the path, depth 32 included
            if (trie_used != 0)
            begin
                for (d = 0; d <= ADDR_BITS; d++)
                begin
                    if (node_as[cur] != 0)
                        res.found_as = node_as[cur];
                    if (d == ADDR_BITS)
                        break;
                    cur = r.address[ADDR_BITS-1-d] ? kid1[cur] : kid0[cur];
                    if (cur == 0)
                        break;
                end
            end
            res.status = lpt_pkg::STATUS_OK;
        end
        else
        begin
            plen = (r.prefix_length > ADDR_BITS) ? ADDR_BITS : int'(r.prefix_length);
            need = plen + 1 - path_nodes(r.address, plen);
            if (need > TRIE_NODES - int'(trie_used))
                res.status = lpt_pkg::STATUS_FULL;
            else
            begin
                if (trie_used == 0)
                    void'(take_node());
                for (d = 0; d < plen; d++)
                begin
                    nxt = r.address[ADDR_BITS-1-d] ? kid1[cur] : kid0[cur];
                    if (nxt == 0)
                    begin
                        nxt = take_node();
                        if (r.address[ADDR_BITS-1-d])
                            kid1[cur] = nxt;
                        else
                            kid0[cur] = nxt;
                    end
                    cur = nxt;
                end
                if (node_as[cur] != 0)
                    res.status = lpt_pkg::STATUS_DUP;
                else
                begin
                    node_as[cur] = r.as_number;
                    res.status   = lpt_pkg::STATUS_OK;
                end
            end
        end
        return res;
    endfunction

    function automatic lpt_pkg::req_t make_req(logic kind, logic [ADDR_BITS-1:0] addr,
                                               logic [PLEN_W-1:0] plen,
                                               logic [AS_W-1:0] asn);
        lpt_pkg::req_t r;
        r.kind          = kind;
        r.address       = addr;
        r.prefix_length = plen;
        r.as_number     = asn;
        return r;
    endfunction

    // Mostly well-formed traffic: lookups under known routes, duplicates and extensions
    function automatic lpt_pkg::req_t random_req();
        lpt_pkg::req_t r;
        route_t pick;
        logic [ADDR_BITS-1:0] keep;
        int roll;
        int pl;
        r       = '0;
        pick    = '0;
        r.kind  = $urandom_range(1, 0) ? lpt_pkg::KIND_LOOKUP : lpt_pkg::KIND_INSERT;
        r.address = $urandom;
        roll    = $urandom_range(99, 0);
        if (routes.size() != 0)
            pick = routes[$urandom_range(routes.size() - 1, 0)];
        keep = 32'hFFFF_FFFF << (ADDR_BITS - int'(pick.plen));
        if (r.kind == lpt_pkg::KIND_LOOKUP)
        begin
            // ignored fields carry noise
            r.prefix_length = PLEN_W'($urandom);
            r.as_number     = $urandom;
            if (routes.size() != 0 && roll < 60)
                r.address = (pick.address & keep) | (r.address & ~keep);
        end
        else
        begin
            case ($urandom_range(19, 0))
                0:       r.as_number = '0;
                1:       r.as_number = 32'hFFFF_FFFF;
                default: r.as_number = $urandom;
            endcase
            if (routes.size() != 0 && roll < 15)
            begin
                r.address       = (pick.address & keep) | (r.address & ~keep);
                r.prefix_length = pick.plen;
            end
            else if (routes.size() != 0 && roll < 40)
            begin
                pl = int'(pick.plen) + $urandom_range(4, 1);
                if (pl > ADDR_BITS)
                    pl = ADDR_BITS;
                r.address       = (pick.address & keep) | (r.address & ~keep);
                r.prefix_length = 6'(pl);
            end
            else
            begin
                roll = $urandom_range(99, 0);
                if (roll < 70)
                    r.prefix_length = 6'($urandom_range(12, 0));
                else if (roll < 90)
                    r.prefix_length = 6'($urandom_range(24, 13));
                else
                    r.prefix_length = 6'($urandom_range(63, 25));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [AS_W-1:0] got, logic [AS_W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Send one transaction; enter and leave at a falling edge
    task automatic send_req(lpt_pkg::req_t r);
        lpt_pkg::rsp_t predicted;
        route_t entry;
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predicted = trie_apply(r);
        pending_rsp.push_back(predicted);
        last_status = predicted.status;
        if (r.kind == lpt_pkg::KIND_INSERT && predicted.status == lpt_pkg::STATUS_OK)
        begin
            entry.address = r.address;
            entry.plen    = (r.prefix_length > ADDR_BITS) ? 6'(ADDR_BITS) : r.prefix_length;
            routes.push_back(entry);
        end
        @(negedge clk);
    endtask

    // Stop sending until every expected response has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_directed();
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0000_0000, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'h3F, 32'hFFFF_FFFF));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h0A00_0000, 6'd8, 32'd100));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h0000_0000, 6'd0, 32'd7));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0B00_0000, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'd0));
        // same prefix again is refused
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h0A00_0000, 6'd8, 32'd5));
        // lengths beyond 32 saturate
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h0A00_0000, 6'd33, 32'h1234_5678));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0A00_0000, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0A00_0001, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h0000_0001, 6'h3F, 32'h8000_0000));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0000_0001, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h0000_0000, 6'd0, 32'd0));
        // zero AS leaves the node empty, so a later insert there succeeds
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'hC0A8_0000, 6'd16, 32'd0));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'hC0A8_0101, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'hC0A8_0000, 6'd16, 32'd9));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'hC0A8_0101, 6'd0, 32'd0));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h0000_0000, 6'd0, 32'd3));
        send_req(make_req(lpt_pkg::KIND_INSERT, 32'h5555_5555, 6'd20, 32'h2AAA_AAAA));
        send_req(make_req(lpt_pkg::KIND_LOOKUP, 32'h5555_5FFF, 6'd0, 32'd0));
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_req(random_req());
    endtask

    // Hold the response side off long enough for the block to stall its input
    task automatic test_backpressure();
        wait_drained();
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        @(negedge clk);
        repeat (20)
            send_req(random_req());
    endtask

    // Exhaust the node pool, fill it exactly, then keep working on a full store
    task automatic test_store_full();
        lpt_pkg::req_t r;
        int tries;
        int spare;
        int pl;
        r      = make_req(lpt_pkg::KIND_INSERT, 32'd0, 6'd32, 32'd1);
        tries  = 0;
        last_status = lpt_pkg::STATUS_OK;
        while (last_status != lpt_pkg::STATUS_FULL && tries < 400)
        begin
            r.address   = $urandom;
            r.as_number = $urandom | 32'd1;
            send_req(r);
            tries++;
        end
        spare = TRIE_NODES - int'(trie_used);
        for (tries = 0; tries < 20 && spare > 0; tries++)
        begin
            r.address = $urandom;
            pl = spare + path_nodes(r.address, ADDR_BITS) - 1;
            if (pl <= ADDR_BITS)
            begin
                r.prefix_length = 6'(pl);
                send_req(r);
                break;
            end
        end
        repeat (40)
            send_req(random_req());
    endtask

    // Drive response stall, with a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_stall   <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
            rsp_stall <= ($urandom_range(99, 0) < rsp_idle_pct);
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response", rsp.found_as, '0);
            else
            begin
                oldest_rsp = pending_rsp.pop_front();
                if (rsp.found_as !== oldest_rsp.found_as)
                    report_mismatch("found_as", rsp.found_as, oldest_rsp.found_as);
                if (rsp.status !== oldest_rsp.status)
                    report_mismatch("status", 32'(rsp.status), 32'(oldest_rsp.status));
            end
        end
    end

    // End the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 11;
        rsp_idle_pct  = 70;
        test_directed();
        test_random(130);

        send_idle_pct = 70;
        rsp_idle_pct  = 11;
        test_random(130);

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        test_backpressure();
        test_random(130);
        test_store_full();

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hdl/lpt_pkg.sv
hdl/lpt_front.sv
hdl/lpt_queue.sv
hdl/lpt_engine.sv
hdl/ipv4_longest_prefix_trie_top.sv
tb/tb.sv
